// ----- hdl/dee_pkg.sv -----
// Shared types, character codes and saturating arithmetic helpers for the expression evaluator.
package dee_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int DIGIT_WIDTH = 4;
    localparam int ACC_WIDTH   = VALUE_WIDTH + DIGIT_WIDTH;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
    localparam int MUL_STEPS   = DIGIT_WIDTH;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic signed [DIGIT_WIDTH:0] DIGIT_BAD = -5'sd1;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [DIGIT_WIDTH:0]   digit_t;

    localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_FIRST,
        OP_EXPECT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                   start;
        logic                   is_div;
        logic [DIGIT_WIDTH-1:0] digit;
    } md_req_t;

    function automatic digit_t digit_value(logic [7:0] sym);
        logic [7:0] offs;
        offs = sym - CHAR_ZERO;
        if (sym >= CHAR_ZERO && sym <= CHAR_NINE)
            return digit_t'({1'b0, offs[DIGIT_WIDTH-1:0]});
        else
            return DIGIT_BAD;
    endfunction

    function automatic value_t sat_add(value_t a, value_t b);
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
            return s[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
        else
            return value_t'(s[VALUE_WIDTH-1:0]);
    endfunction

    function automatic value_t sat_neg(value_t a);
        if (a == VALUE_MIN)
            return VALUE_MAX;
        else
            return -a;
    endfunction

    function automatic logic [OUT_WIDTH-1:0] to_out(value_t a);
        logic [VALUE_WIDTH+OUT_WIDTH-1:0] ext;
        ext = {{OUT_WIDTH{a[VALUE_WIDTH-1]}}, a};
        return ext[OUT_WIDTH-1:0];
    endfunction

endpackage

// ----- hdl/dee_muldiv.sv -----
// Shared shift-add multiplier and restoring divider for a term by a single positive digit.
module dee_muldiv
    import dee_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    input  value_t  operand,
    output logic    done,
    output value_t  result
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   div_reg, div_next;
    logic                   neg_reg, neg_next;
    logic [DIGIT_WIDTH-1:0] digit_reg, digit_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic [DIGIT_WIDTH-1:0] rem_reg, rem_next;
    value_t                 opnd_reg, opnd_next;

    logic [VALUE_WIDTH-1:0]           mag;
    logic [DIGIT_WIDTH:0]             trial;
    logic [ACC_WIDTH-1:0]             op_a;
    logic [ACC_WIDTH-1:0]             op_b;
    logic [ACC_WIDTH-1:0]             adder;
    logic                             qbit;
    logic [ACC_WIDTH-VALUE_WIDTH:0]   prod_top;
    value_t                           quot;

    assign mag   = operand[VALUE_WIDTH-1] ? -operand : operand;
    assign trial = {rem_reg, acc_reg[VALUE_WIDTH-1]};

    // One adder serves both modes: accumulate for multiply, trial subtract for divide.
    always_comb
    begin
        if (div_reg)
        begin
            op_a = {{(ACC_WIDTH-DIGIT_WIDTH-1){1'b0}}, trial};
            op_b = ~{{(ACC_WIDTH-DIGIT_WIDTH){1'b0}}, digit_reg};
        end
        else
        begin
            op_a = {acc_reg[ACC_WIDTH-2:0], 1'b0};
            op_b = digit_reg[cnt_reg[$clog2(MUL_STEPS)-1:0]]
                 ? {{DIGIT_WIDTH{opnd_reg[VALUE_WIDTH-1]}}, opnd_reg}
                 : '0;
        end
        adder = op_a + op_b + {{(ACC_WIDTH-1){1'b0}}, div_reg};
    end

    assign qbit = ~adder[ACC_WIDTH-1];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        div_next   = div_reg;
        neg_next   = neg_reg;
        digit_next = digit_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        opnd_next  = opnd_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            div_next   = req.is_div;
            digit_next = req.digit;
            neg_next   = operand[VALUE_WIDTH-1];
            opnd_next  = operand;
            rem_next   = '0;
            if (req.is_div)
            begin
                cnt_next = CNT_WIDTH'(VALUE_WIDTH - 1);
                acc_next = {{(ACC_WIDTH-VALUE_WIDTH){1'b0}}, mag};
            end
            else
            begin
                cnt_next = CNT_WIDTH'(MUL_STEPS - 1);
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_next = qbit ? adder[DIGIT_WIDTH-1:0] : trial[DIGIT_WIDTH-1:0];
                acc_next = {{(ACC_WIDTH-VALUE_WIDTH){1'b0}},
                            acc_reg[VALUE_WIDTH-2:0], qbit};
            end
            else
            begin
                acc_next = adder;
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        neg_reg   <= neg_next;
        digit_reg <= digit_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        opnd_reg  <= opnd_next;
    end

    assign prod_top = acc_reg[ACC_WIDTH-1:VALUE_WIDTH-1];
    assign quot     = value_t'(acc_reg[VALUE_WIDTH-1:0]);

    always_comb
    begin
        if (div_reg)
            result = neg_reg ? -quot : quot;
        else if ((&prod_top) || !(|prod_top))
            result = value_t'(acc_reg[VALUE_WIDTH-1:0]);
        else
            result = acc_reg[ACC_WIDTH-1] ? VALUE_MIN : VALUE_MAX;
    end

    assign done = done_reg;

endmodule

// ----- hdl/digit_expression_evaluator_unit.sv -----
// Top level: character sequencer, accumulators and result register of the expression evaluator.
//
// Evaluates an infix expression of single digits and + - * / given one character per
// transaction, with * and / binding tighter than + and -, and gives one result on the
// transaction marked last. An operator, or a digit after +, - or at the start, is
// handled by the sequencer alone. A digit after * or / (other than 0 or a non-digit)
// runs through the shared multiply/divide unit: 4 shift-add steps over the digit bits
// for a multiply, one quotient bit per cycle for a divide, and new characters stall.
// The last character then passes the emit state, which loads the result register; the
// next expression may start while that result still waits to be taken.
module digit_expression_evaluator_unit
    import dee_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sym_valid,
    output logic                 sym_stall,
    input  logic [7:0]           symbol,
    input  logic                 last,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [OUT_WIDTH-1:0] value,
    output logic                 impossible
);

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    value_t               sum_reg, sum_next;
    value_t               term_reg, term_next;
    logic                 dz_reg, dz_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_WIDTH-1:0] out_value_reg, out_value_next;
    logic                 out_imp_reg, out_imp_next;

    logic    sym_accept;
    logic    emit_load;
    digit_t  dig;
    value_t  dig_ext;
    md_req_t md_req;
    logic    md_done;
    value_t  md_result;

    dee_muldiv u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (md_req),
        .operand (term_reg),
        .done    (md_done),
        .result  (md_result)
    );

    assign sym_stall  = (state_reg != ST_IDLE);
    assign sym_accept = sym_valid && !sym_stall;
    assign dig        = digit_value(symbol);
    assign dig_ext    = {{(VALUE_WIDTH-DIGIT_WIDTH-1){dig[DIGIT_WIDTH]}}, dig};
    assign emit_load  = (state_reg == ST_EMIT) && (!out_valid_reg || !res_stall);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        sum_next       = sum_reg;
        term_next      = term_reg;
        dz_next        = dz_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_imp_next   = out_imp_reg;
        md_req         = '0;
        md_req.digit   = dig[DIGIT_WIDTH-1:0];

        if (out_valid_reg && !res_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sym_accept)
                begin
                    last_next  = last;
                    state_next = last ? ST_EMIT : ST_IDLE;
                    if (op_reg == OP_EXPECT)
                    begin
                        case (symbol)
                            CHAR_STAR:  op_next = OP_MUL;
                            CHAR_SLASH: op_next = OP_DIV;
                            CHAR_PLUS:  op_next = OP_ADD;
                            default:    op_next = OP_SUB;
                        endcase
                    end
                    else
                    begin
                        op_next = OP_EXPECT;
                        case (op_reg)
                            OP_ADD:
                            begin
                                sum_next  = sat_add(sum_reg, term_reg);
                                term_next = dig_ext;
                            end
                            OP_SUB:
                            begin
                                sum_next  = sat_add(sum_reg, term_reg);
                                term_next = -dig_ext;
                            end
                            OP_MUL:
                            begin
                                if (dig == '0)
                                    term_next = '0;
                                else if (dig[DIGIT_WIDTH])
                                    term_next = sat_neg(term_reg);
                                else
                                begin
                                    md_req.start  = 1'b1;
                                    md_req.is_div = 1'b0;
                                    state_next    = ST_CALC;
                                end
                            end
                            OP_DIV:
                            begin
                                if (dig == '0)
                                    dz_next = 1'b1;
                                else if (dig[DIGIT_WIDTH])
                                    term_next = sat_neg(term_reg);
                                else
                                begin
                                    md_req.start  = 1'b1;
                                    md_req.is_div = 1'b1;
                                    state_next    = ST_CALC;
                                end
                            end
                            default:
                            begin
                                term_next = dig_ext;
                            end
                        endcase
                    end
                end
            end
            ST_CALC:
            begin
                if (md_done)
                begin
                    term_next  = md_result;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    out_imp_next   = dz_reg;
                    out_value_next = dz_reg ? '0 : to_out(sat_add(sum_reg, term_reg));
                    sum_next       = '0;
                    term_next      = '0;
                    op_next        = OP_FIRST;
                    dz_next        = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_FIRST;
            sum_reg       <= '0;
            term_reg      <= '0;
            dz_reg        <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            dz_reg        <= dz_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_imp_reg   <= out_imp_next;
    end

    assign res_valid  = out_valid_reg;
    assign value      = out_value_reg;
    assign impossible = out_imp_reg;

`ifndef SYNTHESIS
    // The arithmetic unit only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> state_reg == ST_CALC)
        else $error("multiply/divide unit finished outside the calculate state");

    // A flagged division by zero always reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && impossible) |-> value == '0)
        else $error("impossible result carries a nonzero value");

    // A new result only appears after the emit state loaded it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_EMIT))
        else $error("result valid rose without an emit");

    // Emitting a result returns the evaluator to its start-of-expression state.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> (op_reg == OP_FIRST && !dz_reg && sum_reg == '0 && term_reg == '0))
        else $error("accumulators not cleared after emit");
`endif

endmodule
